/* rtl/tccs_pkg.sv */
// tccs_pkg: shared constants, codes and types of the text console core
// no dependencies; imported by every module of the block

package tccs_pkg;

   // geometry of the character memory
   localparam int COLUMNS    = 80;
   localparam int MAX_ROWS   = 64;
   localparam int TAB_SPACES = 8;

   localparam int CELLS  = COLUMNS * MAX_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   // sweep address also runs one row past the end while blanking
   localparam int SCR_W  = $clog2(CELLS + COLUMNS + 1);
   localparam int REM_W  = $clog2(TAB_SPACES + 1);

   // field widths
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 6;
   localparam int CFG_W  = 7;

   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(25);

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_DATA,
      ST_WRITE,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_ADVANCE,
      OP_NEWLINE,
      OP_BACKSPACE
   } op_type;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] character;
      logic [COL_W-1:0]  read_column;
      logic [ROW_W-1:0]  read_row;
   } tccs_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_character;
      logic [COL_W-1:0]  cursor_column;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } tccs_rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tccs_ram_cmd_type;

endpackage

/* rtl/tccs_cell_ram.sv */
// tccs_cell_ram: character memory, one write and one registered read port
// depends on tccs_pkg

module tccs_cell_ram (
   input  logic                           clock,
   input  tccs_pkg::tccs_ram_cmd_type     cmd,
   output logic [tccs_pkg::CHAR_W-1:0]    rd_data
);
   import tccs_pkg::*;

   logic [CHAR_W-1:0] mem [CELLS];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tccs_ctrl.sv */
// tccs_ctrl: sequencer of the console; cursor, clearing sweep, scroll copy
// depends on tccs_pkg; drives the tccs_cell_ram ports

module tccs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tccs_pkg::CFG_W-1:0]    rows_cfg,
   input  logic                          req_accept,
   input  tccs_pkg::tccs_req_type        req,
   output logic                          ready,
   input  logic                          out_free,
   output logic                          done,
   output tccs_pkg::tccs_rsp_type        rsp,
   output tccs_pkg::tccs_ram_cmd_type    ram_cmd,
   input  logic [tccs_pkg::CHAR_W-1:0]   ram_rd_data
);
   import tccs_pkg::*;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [CFG_W-1:0]  rows_ff, rows_in;
   logic [SCR_W-1:0]  end_ff, end_in;
   logic [SCR_W-1:0]  scr_ff, scr_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [CHAR_W-1:0] wr_char_ff, wr_char_in;
   logic [CHAR_W-1:0] cell_ff, cell_in;
   logic              scrolled_ff, scrolled_in;
   logic              in_range_ff, in_range_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;

   logic [CFG_W-1:0]  rows_clamped;
   logic [ROW_W-1:0]  line_put;
   logic [ADDR_W-1:0] cursor_addr;
   logic [SCR_W-1:0]  scr_back;

   always_comb begin
      if (rows_cfg == '0) begin
         rows_clamped = CFG_W'(1);
      end else if (rows_cfg > CFG_W'(MAX_ROWS)) begin
         rows_clamped = CFG_W'(MAX_ROWS);
      end else begin
         rows_clamped = rows_cfg;
      end
   end

   // cursor below the active area moves up to its last row on a put
   assign line_put = ({1'b0, line_ff} >= rows_clamped) ?
                     ROW_W'(rows_clamped - CFG_W'(1)) : line_ff;

   assign cursor_addr = ADDR_W'(ADDR_W'(line_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff));
   assign scr_back    = scr_ff - SCR_W'(COLUMNS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         scr_ff   <= '0;
         col_ff   <= '0;
         line_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scr_ff   <= scr_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rows_ff     <= rows_in;
      end_ff      <= end_in;
      rem_ff      <= rem_in;
      wr_char_ff  <= wr_char_in;
      cell_ff     <= cell_in;
      scrolled_ff <= scrolled_in;
      in_range_ff <= in_range_in;
      rd_addr_ff  <= rd_addr_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      col_in      = col_ff;
      line_in     = line_ff;
      rows_in     = rows_ff;
      end_in      = end_ff;
      scr_in      = scr_ff;
      rem_in      = rem_ff;
      wr_char_in  = wr_char_ff;
      cell_in     = cell_ff;
      scrolled_in = scrolled_ff;
      in_range_in = in_range_ff;
      rd_addr_in  = rd_addr_ff;
      ready       = 1'b0;
      done        = 1'b0;
      ram_cmd     = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = scr_ff[ADDR_W-1:0];
            ram_cmd.wr_data = CH_SPACE;
            scr_in          = scr_ff + SCR_W'(1);
            if (scr_ff == SCR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            ready = 1'b1;
            if (req_accept) begin
               rows_in     = rows_clamped;
               end_in      = SCR_W'(SCR_W'(rows_clamped) * SCR_W'(COLUMNS));
               scrolled_in = 1'b0;
               cell_in     = CH_SPACE;
               if (req.command == CMD_READ) begin
                  in_range_in = ({1'b0, req.read_column} < (COL_W + 1)'(COLUMNS)) &&
                                ({1'b0, req.read_row} < rows_clamped);
                  rd_addr_in  = ADDR_W'(ADDR_W'(req.read_row) * ADDR_W'(COLUMNS) +
                                        ADDR_W'(req.read_column));
                  state_in    = ST_READ;
               end else begin
                  line_in = line_put;
                  rem_in  = REM_W'(1);
                  case (req.character)
                     CH_NEWLINE: begin
                        op_in      = OP_NEWLINE;
                        wr_char_in = CH_SPACE;
                     end
                     CH_BACKSPACE: begin
                        op_in      = OP_BACKSPACE;
                        wr_char_in = CH_SPACE;
                     end
                     CH_TAB: begin
                        op_in      = OP_ADVANCE;
                        wr_char_in = CH_SPACE;
                        rem_in     = REM_W'(TAB_SPACES);
                     end
                     default: begin
                        op_in      = OP_ADVANCE;
                        wr_char_in = req.character;
                     end
                  endcase
                  state_in = ST_WRITE;
               end
            end
         end

         ST_READ: begin
            if (in_range_ff) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = rd_addr_ff;
               state_in        = ST_READ_DATA;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_READ_DATA: begin
            cell_in  = ram_rd_data;
            state_in = ST_DONE;
         end

         ST_WRITE: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = cursor_addr;
            ram_cmd.wr_data = wr_char_ff;
            rem_in          = rem_ff - REM_W'(1);
            state_in        = (rem_ff == REM_W'(1)) ? ST_DONE : ST_WRITE;
            if (op_ff == OP_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_in = col_ff - COL_W'(1);
               end
            end else if ((op_ff == OP_NEWLINE) ||
                         ({1'b0, col_ff} >= (COL_W + 1)'(COLUMNS - 1))) begin
               // start of next line, scrolling at the last active row
               col_in = '0;
               if ({1'b0, line_ff} >= rows_ff - CFG_W'(1)) begin
                  line_in     = ROW_W'(rows_ff - CFG_W'(1));
                  scrolled_in = 1'b1;
                  scr_in      = SCR_W'(COLUMNS);
                  state_in    = (rows_ff == CFG_W'(1)) ? ST_BLANK : ST_SCROLL_RD;
               end else begin
                  line_in = line_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end

         ST_SCROLL_RD: begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = scr_ff[ADDR_W-1:0];
            state_in        = ST_SCROLL_WR;
         end

         ST_SCROLL_WR: begin
            // copy the cell one row up
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = scr_back[ADDR_W-1:0];
            ram_cmd.wr_data = ram_rd_data;
            scr_in          = scr_ff + SCR_W'(1);
            state_in        = (scr_ff == end_ff - SCR_W'(1)) ? ST_BLANK : ST_SCROLL_RD;
         end

         ST_BLANK: begin
            // blank the last active row, one row behind the sweep address
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = scr_back[ADDR_W-1:0];
            ram_cmd.wr_data = CH_SPACE;
            scr_in          = scr_ff + SCR_W'(1);
            if (scr_ff == end_ff + SCR_W'(COLUMNS - 1)) begin
               state_in = (rem_ff == '0) ? ST_DONE : ST_WRITE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.cell_character = cell_ff;
      rsp.cursor_column  = col_ff;
      rsp.cursor_row     = line_ff;
      rsp.scrolled       = scrolled_ff;
   end

endmodule

/* rtl/text_console_cursor_scroll_core.sv */
// Text console core: character memory with cursor, newline, backspace,
// tab and scroll. One request word in, one response word out.
//
// Request channel (req_): command 0 puts req_character at the cursor,
// command 1 reads the cell at req_read_column / req_read_row. A word is
// taken when req_valid is high and req_stall is low; the core handles
// one word at a time and holds req_stall high until it is finished.
// Response channel (rsp_): one word per request with the read cell (space
// for a put), the cursor after the request and the scroll flag. The
// response sits in an output register; while the receiver stalls, the
// core still takes the next request but will not finish it until the
// register is free.
// Every request is walked in a sequencer loop that owns the single memory
// port pair; a tab writes spaces cell by cell. A scroll reads every active
// cell below the top row and writes it back one row up, then blanks the
// last active row.
// Reset: rows in use returns to 25, the cursor to the top left, and a
// clearing sweep writes a space into all 5120 cells, during which no
// request is taken. csr_write_enable writes rows in use at once.

module text_console_cursor_scroll_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [tccs_pkg::CFG_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [tccs_pkg::CHAR_W-1:0]   req_character,
   input  logic [tccs_pkg::COL_W-1:0]    req_read_column,
   input  logic [tccs_pkg::ROW_W-1:0]    req_read_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tccs_pkg::CHAR_W-1:0]   rsp_cell_character,
   output logic [tccs_pkg::COL_W-1:0]    rsp_cursor_column,
   output logic [tccs_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic                          rsp_scrolled
);
   import tccs_pkg::*;

   logic [CFG_W-1:0]  rows_in_use_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tccs_rsp_type      rsp_ff;
   tccs_rsp_type      ctrl_rsp;
   tccs_req_type      req;
   tccs_ram_cmd_type  ram_cmd;
   logic [CHAR_W-1:0] ram_rd_data;
   logic              ready;
   logic              req_accept;
   logic              out_free;
   logic              done;

   assign req_stall  = ~ready;
   assign req_accept = req_valid & ready;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      req.command     = req_command;
      req.character   = req_character;
      req.read_column = req_read_column;
      req.read_row    = req_read_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_RESET;
      end else if (csr_write_enable) begin
         rows_in_use_ff <= csr_write_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= ctrl_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_character = rsp_ff.cell_character;
   assign rsp_cursor_column  = rsp_ff.cursor_column;
   assign rsp_cursor_row     = rsp_ff.cursor_row;
   assign rsp_scrolled       = rsp_ff.scrolled;

   tccs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .rows_cfg    (rows_in_use_ff),
      .req_accept  (req_accept),
      .req         (req),
      .ready       (ready),
      .out_free    (out_free),
      .done        (done),
      .rsp         (ctrl_rsp),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   tccs_cell_ram u_cell_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

endmodule
